// File: rtl/core/tsnt_pkg.sv
// Shared types and constants for the tangent-space normal transform.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tsnt_pkg;

    // Component format: signed, two integer bits, the rest fraction.
    localparam int COMP_W   = 16;
    localparam int FRAC_W   = COMP_W - 2;
    // Products are pre-shifted only when the fraction is wide enough to overflow 64 bits.
    localparam int SUM_SHIFT = (2 * FRAC_W > 57) ? (2 * FRAC_W - 57) : 0;
    // Squared tangent length below this counts as a zero-length tangent (0.0001 squared).
    localparam logic [63:0] SHORT_THRESH =
        ((64'd1 << (2 * FRAC_W)) + 64'd99999999) / 64'd100000000;

    // Normalizer: magnitudes are scaled so the largest one has its top bit at SCALE_MSB.
    localparam int SCALE_MSB  = 29;
    localparam int SCALED_W   = SCALE_MSB + 1;
    localparam int SQ_W       = 2 * SCALED_W;
    localparam int ACC_W      = 64;
    localparam int SQRT_STEPS = 32;
    localparam int ROOT_W     = SCALED_W + 1;

    // Width of the weighted sum that feeds the second normalizer.
    localparam int SUM_W = 2 * COMP_W + 2;

    typedef struct packed {
        logic signed [COMP_W-1:0] surf_x;
        logic signed [COMP_W-1:0] surf_y;
        logic signed [COMP_W-1:0] surf_z;
        logic signed [COMP_W-1:0] map_x;
        logic signed [COMP_W-1:0] map_y;
        logic signed [COMP_W-1:0] map_z;
    } t_in_req;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     degenerate;
    } t_out_req;

endpackage

`default_nettype wire

// File: rtl/core/tsnt_basis.sv
// Tangent selection: n x (+Z), or n x (+Y) when that one is too short.
// Depends on tsnt_pkg. Two register stages, held by the pipeline enable.
`default_nettype none

module tsnt_basis import tsnt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  t_in_req                   i_req,
    output logic                      o_valid,
    output logic [2:0][COMP_W:0]      o_tan,
    output t_in_req                   o_req
);

    localparam int PR_W  = 2 * COMP_W;
    localparam int LEN_W = PR_W + 1;
    localparam int T_W   = COMP_W + 1;

    logic                    r_a_v;
    logic [PR_W-1:0]         r_a_xx;
    logic [PR_W-1:0]         r_a_yy;
    t_in_req                 r_a_req;
    logic signed [PR_W-1:0]  n_xx;
    logic signed [PR_W-1:0]  n_yy;

    logic                    r_b_v;
    logic [2:0][T_W-1:0]     r_b_tan;
    t_in_req                 r_b_req;
    logic [LEN_W-1:0]        n_len2;
    logic [2:0][T_W-1:0]     n_tan;

    always_comb begin
        n_xx = PR_W'(i_req.surf_x) * PR_W'(i_req.surf_x);
        n_yy = PR_W'(i_req.surf_y) * PR_W'(i_req.surf_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xx  <= n_xx;
            r_a_yy  <= n_yy;
            r_a_req <= i_req;
        end
    end

    always_comb begin
        n_len2 = LEN_W'(r_a_xx) + LEN_W'(r_a_yy);
        if (n_len2 < LEN_W'(SHORT_THRESH)) begin
            n_tan[0] = -T_W'(r_a_req.surf_z);
            n_tan[1] = '0;
            n_tan[2] = T_W'(r_a_req.surf_x);
        end else begin
            n_tan[0] = T_W'(r_a_req.surf_y);
            n_tan[1] = -T_W'(r_a_req.surf_x);
            n_tan[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_tan <= n_tan;
            r_b_req <= r_a_req;
        end
    end

    assign o_valid = r_b_v;
    assign o_tan   = r_b_tan;
    assign o_req   = r_b_req;

endmodule

`default_nettype wire

// File: rtl/core/tsnt_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Depends on tsnt_pkg. One step of the root and one quotient bit per stage.
`default_nettype none

module tsnt_norm import tsnt_pkg::*; #(
    parameter int IN_W   = 17,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][IN_W-1:0]      i_vec,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [2:0][COMP_W-1:0]    o_vec,
    output logic                      o_zero,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int P_W   = $clog2(IN_W);
    localparam int EXT_W = IN_W + SCALED_W;
    localparam int SH_W  = $clog2(EXT_W);
    localparam int RW    = ROOT_W + FRAC_W;
    localparam int Q_W   = FRAC_W + 1;

    typedef struct packed {
        logic [ACC_W-1:0]               x;
        logic [ACC_W-1:0]               r;
        logic [2:0][SCALED_W-1:0]       sc;
        logic [2:0]                     neg;
        logic                           zero;
        logic [SIDE_W-1:0]              side;
    } t_sq;

    typedef struct packed {
        logic [2:0][RW-1:0]             rem;
        logic [2:0][Q_W-1:0]            q;
        logic [ROOT_W-1:0]              root;
        logic [2:0]                     neg;
        logic                           zero;
        logic [SIDE_W-1:0]              side;
    } t_dv;

    // Stage 1: magnitudes and their maximum.
    logic [2:0][IN_W-1:0]   n_mag;
    logic [IN_W-1:0]        n_max;
    logic                   r1_v;
    logic [2:0][IN_W-1:0]   r1_mag;
    logic [2:0]             r1_neg;
    logic [IN_W-1:0]        r1_max;
    logic [SIDE_W-1:0]      r1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][IN_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        n_max = n_mag[0];
        if (n_mag[1] > n_max) n_max = n_mag[1];
        if (n_mag[2] > n_max) n_max = n_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n_mag;
            r1_max  <= n_max;
            r1_side <= i_side;
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_vec[i][IN_W-1];
            end
        end
    end

    // Stage 2: leading-one position of the maximum gives the scaling shift.
    logic [P_W-1:0]         n_pos;
    logic [SH_W-1:0]        n_lsh;
    logic [SH_W-1:0]        n_rsh;
    logic                   r2_v;
    logic [2:0][IN_W-1:0]   r2_mag;
    logic [2:0]             r2_neg;
    logic                   r2_zero;
    logic [SH_W-1:0]        r2_lsh;
    logic [SH_W-1:0]        r2_rsh;
    logic [SIDE_W-1:0]      r2_side;

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (r1_max[b]) n_pos = P_W'(b);
        end
        n_lsh = '0;
        n_rsh = '0;
        if (int'(n_pos) < SCALE_MSB) begin
            n_lsh = SH_W'(SCALE_MSB - int'(n_pos));
        end else begin
            n_rsh = SH_W'(int'(n_pos) - SCALE_MSB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_max == '0);
            r2_lsh  <= n_lsh;
            r2_rsh  <= n_rsh;
            r2_side <= r1_side;
        end
    end

    // Stage 3: apply the shift; right shifts drop the low bits.
    logic [2:0][EXT_W-1:0]      n_ext;
    logic                       r3_v;
    logic [2:0][SCALED_W-1:0]   r3_sc;
    logic [2:0]                 r3_neg;
    logic                       r3_zero;
    logic [SIDE_W-1:0]          r3_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ext[i] = (EXT_W'(r2_mag[i]) << r2_lsh) >> r2_rsh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sc[i] <= n_ext[i][SCALED_W-1:0];
            end
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_side <= r2_side;
        end
    end

    // Stage 4: squares.
    logic                       r4_v;
    logic [2:0][SQ_W-1:0]       r4_sq;
    logic [2:0][SCALED_W-1:0]   r4_sc;
    logic [2:0]                 r4_neg;
    logic                       r4_zero;
    logic [SIDE_W-1:0]          r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= SQ_W'(r3_sc[i]) * SQ_W'(r3_sc[i]);
            end
            r4_sc   <= r3_sc;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r4_side <= r3_side;
        end
    end

    // Stage 5 loads the root pipeline with the sum of squares.
    t_sq    r_sq   [0:SQRT_STEPS];
    logic   r_sq_v [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0].x    <= ACC_W'(r4_sq[0]) + ACC_W'(r4_sq[1]) + ACC_W'(r4_sq[2]);
            r_sq[0].r    <= '0;
            r_sq[0].sc   <= r4_sc;
            r_sq[0].neg  <= r4_neg;
            r_sq[0].zero <= r4_zero;
            r_sq[0].side <= r4_side;
        end
    end

    // Digit-by-digit floor square root, one result bit per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [ACC_W-1:0] STEP_BIT = ACC_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        t_sq                n_s;
        logic [ACC_W-1:0]   n_trial;

        always_comb begin
            n_s     = r_sq[j];
            n_trial = r_sq[j].r + STEP_BIT;
            if (r_sq[j].x >= n_trial) begin
                n_s.x = r_sq[j].x - n_trial;
                n_s.r = (r_sq[j].r >> 1) + STEP_BIT;
            end else begin
                n_s.r = r_sq[j].r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[j+1] <= n_s;
            end
        end
    end

    // Division set-up: dividend carries half the divisor so the quotient rounds.
    t_dv                n_dv0;
    logic [ROOT_W-1:0]  n_root;
    t_dv                r_dv   [0:Q_W];
    logic               r_dv_v [0:Q_W];

    always_comb begin
        n_root        = r_sq[SQRT_STEPS].r[ROOT_W-1:0];
        n_dv0.root    = n_root;
        n_dv0.q       = '0;
        n_dv0.neg     = r_sq[SQRT_STEPS].neg;
        n_dv0.zero    = r_sq[SQRT_STEPS].zero;
        n_dv0.side    = r_sq[SQRT_STEPS].side;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = (RW'(r_sq[SQRT_STEPS].sc[i]) << FRAC_W) + RW'(n_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        t_dv            n_d;
        logic [RW-1:0]  n_cmp;

        always_comb begin
            n_d   = r_dv[j];
            n_cmp = RW'(r_dv[j].root) << (FRAC_W - j);
            for (int i = 0; i < 3; i++) begin
                if (r_dv[j].rem[i] >= n_cmp) begin
                    n_d.rem[i]             = r_dv[j].rem[i] - n_cmp;
                    n_d.q[i][FRAC_W - j]   = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j+1] <= n_d;
            end
        end
    end

    // Output stage: restore signs. A unit vector never exceeds 1.0, so no clamp is needed.
    logic                       r_o_v;
    logic [2:0][COMP_W-1:0]     r_o_vec;
    logic                       r_o_zero;
    logic [SIDE_W-1:0]          r_o_side;
    logic [2:0][COMP_W-1:0]     n_o_vec;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv[Q_W].zero) begin
                n_o_vec[i] = '0;
            end else if (r_dv[Q_W].neg[i]) begin
                n_o_vec[i] = -COMP_W'(r_dv[Q_W].q[i]);
            end else begin
                n_o_vec[i] = COMP_W'(r_dv[Q_W].q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_dv_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_vec  <= n_o_vec;
            r_o_zero <= r_dv[Q_W].zero;
            r_o_side <= r_dv[Q_W].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_zero  = r_o_zero;
    assign o_side  = r_o_side;

endmodule

`default_nettype wire

// File: rtl/core/tsnt_combine.sv
// Bitangent and weighted sum t*mx + b*my + n*mz ahead of the final normalize.
// Depends on tsnt_pkg. Four register stages, one multiply level in each product stage.
`default_nettype none

module tsnt_combine import tsnt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][COMP_W-1:0]    i_tn,
    input  t_in_req                   i_req,
    output logic                      o_valid,
    output logic [2:0][SUM_W-1:0]     o_sum
);

    localparam int PR_W = 2 * COMP_W;
    localparam int DW   = PR_W + 1;
    localparam int B_W  = COMP_W + 2;
    localparam int PW   = 2 * COMP_W + 2;

    // Stage 1: cross-product terms of n and the unit tangent.
    logic signed [PR_W-1:0]     n_cp [6];
    logic signed [PR_W-1:0]     r1_cp [6];
    logic                       r1_v;
    logic [2:0][COMP_W-1:0]     r1_tn;
    t_in_req                    r1_req;
    logic signed [COMP_W-1:0]   t0, t1, t2;

    always_comb begin
        t0 = $signed(i_tn[0]);
        t1 = $signed(i_tn[1]);
        t2 = $signed(i_tn[2]);
        n_cp[0] = PR_W'(i_req.surf_y) * PR_W'(t2);
        n_cp[1] = PR_W'(i_req.surf_z) * PR_W'(t1);
        n_cp[2] = PR_W'(i_req.surf_z) * PR_W'(t0);
        n_cp[3] = PR_W'(i_req.surf_x) * PR_W'(t2);
        n_cp[4] = PR_W'(i_req.surf_x) * PR_W'(t1);
        n_cp[5] = PR_W'(i_req.surf_y) * PR_W'(t0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cp  <= n_cp;
            r1_tn  <= i_tn;
            r1_req <= i_req;
        end
    end

    // Stage 2: differences, rounded half away from zero back to the component format.
    logic signed [DW-1:0]   n_d   [3];
    logic [DW-1:0]          n_dm  [3];
    logic [DW-1:0]          n_rm  [3];
    logic signed [B_W-1:0]  n_b   [3];
    logic signed [B_W-1:0]  r2_b  [3];
    logic                   r2_v;
    logic [2:0][COMP_W-1:0] r2_tn;
    t_in_req                r2_req;

    always_comb begin
        n_d[0] = DW'(r1_cp[0]) - DW'(r1_cp[1]);
        n_d[1] = DW'(r1_cp[2]) - DW'(r1_cp[3]);
        n_d[2] = DW'(r1_cp[4]) - DW'(r1_cp[5]);
        for (int i = 0; i < 3; i++) begin
            n_dm[i] = n_d[i][DW-1] ? -n_d[i] : n_d[i];
            n_rm[i] = (n_dm[i] + (DW'(1) << (FRAC_W - 1))) >> FRAC_W;
            n_b[i]  = n_d[i][DW-1] ? -B_W'(n_rm[i]) : B_W'(n_rm[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_b   <= n_b;
            r2_tn  <= r1_tn;
            r2_req <= r1_req;
        end
    end

    // Stage 3: the nine weighted products.
    logic signed [PW-1:0]   n_p  [3][3];
    logic signed [PW-1:0]   r3_p [3][3];
    logic                   r3_v;
    logic signed [COMP_W-1:0] n_n [3];

    always_comb begin
        n_n[0] = r2_req.surf_x;
        n_n[1] = r2_req.surf_y;
        n_n[2] = r2_req.surf_z;
        for (int i = 0; i < 3; i++) begin
            n_p[i][0] = PW'($signed(r2_tn[i])) * PW'(r2_req.map_x);
            n_p[i][1] = PW'(r2_b[i]) * PW'(r2_req.map_y);
            n_p[i][2] = PW'(n_n[i]) * PW'(r2_req.map_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p <= n_p;
        end
    end

    // Stage 4: magnitudes truncated by the pre-shift, then summed per component.
    logic [PW-1:0]          n_pm [3][3];
    logic signed [PW-1:0]   n_pt [3][3];
    logic [2:0][SUM_W-1:0]  n_sum;
    logic                   r4_v;
    logic [2:0][SUM_W-1:0]  r4_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_pm[i][k] = (r3_p[i][k][PW-1] ? -r3_p[i][k] : r3_p[i][k]) >> SUM_SHIFT;
                n_pt[i][k] = r3_p[i][k][PW-1] ? -n_pm[i][k] : n_pm[i][k];
            end
            n_sum[i] = SUM_W'(n_pt[i][0]) + SUM_W'(n_pt[i][1]) + SUM_W'(n_pt[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sum <= n_sum;
        end
    end

    assign o_valid = r4_v;
    assign o_sum   = r4_sum;

endmodule

`default_nettype wire

// File: rtl/core/tangent_space_normal_transform.sv
// Top level of the tangent-space normal transform: basis, two normalizers, combine, output skid.
// Depends on tsnt_pkg, tsnt_basis, tsnt_norm and tsnt_combine.
//
// Each request carries a surface normal and a tangent-space map normal in signed Q1.14 and
// yields one unit world-space normal, with a degenerate flag when the weighted sum has zero
// length. The block takes one request per clock while the input is not stalled; each of the
// two normalizers spends 32 stages on the square root and 15 on the rounded divide. Results
// leave in order. An output register and one skid entry let a new request enter while a
// result waits; the input stalls only once the skid entry holds a result.
`default_nettype none

module tangent_space_normal_transform import tsnt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out_req,
    input  logic     i_out_stall
);

    localparam int T_W    = COMP_W + 1;
    localparam int REQ_W  = $bits(t_in_req);

    logic                       w_en;
    logic                       w_bs_v;
    logic [2:0][T_W-1:0]        w_bs_tan;
    t_in_req                    w_bs_req;
    logic                       w_n1_v;
    logic [2:0][COMP_W-1:0]     w_n1_vec;
    logic                       w_n1_zero;
    logic [REQ_W-1:0]           w_n1_side;
    logic                       w_cb_v;
    logic [2:0][SUM_W-1:0]      w_cb_sum;
    logic                       w_n2_v;
    logic [2:0][COMP_W-1:0]     w_n2_vec;
    logic                       w_n2_zero;
    logic                       w_n2_side;
    t_out_req                   w_res;

    logic                       r_out_v;
    t_out_req                   r_out;
    logic                       r_skid_v;
    t_out_req                   r_skid;
    logic                       w_take;
    logic                       w_arrive;

    // The whole pipeline holds only while the skid entry is occupied.
    assign w_en       = !r_skid_v;
    assign o_in_stall = r_skid_v;

    tsnt_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_valid (w_bs_v),
        .o_tan   (w_bs_tan),
        .o_req   (w_bs_req)
    );

    tsnt_norm #(
        .IN_W   (T_W),
        .SIDE_W (REQ_W)
    ) u_norm_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_bs_v),
        .i_vec   (w_bs_tan),
        .i_side  (w_bs_req),
        .o_valid (w_n1_v),
        .o_vec   (w_n1_vec),
        .o_zero  (w_n1_zero),
        .o_side  (w_n1_side)
    );

    tsnt_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n1_v),
        .i_tn    (w_n1_vec),
        .i_req   (t_in_req'(w_n1_side)),
        .o_valid (w_cb_v),
        .o_sum   (w_cb_sum)
    );

    tsnt_norm #(
        .IN_W   (SUM_W),
        .SIDE_W (1)
    ) u_norm_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cb_v),
        .i_vec   (w_cb_sum),
        .i_side  (w_n1_zero),
        .o_valid (w_n2_v),
        .o_vec   (w_n2_vec),
        .o_zero  (w_n2_zero),
        .o_side  (w_n2_side)
    );

    always_comb begin
        w_res.out_x      = $signed(w_n2_vec[0]);
        w_res.out_y      = $signed(w_n2_vec[1]);
        w_res.out_z      = $signed(w_n2_vec[2]);
        w_res.degenerate = w_n2_zero;
    end

    assign w_take   = r_out_v && !i_out_stall;
    assign w_arrive = w_n2_v && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= w_arrive;
        end else if (w_arrive) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire

// File: tb/tangent_space_normal_transform_test.sv
// Testbench for the tangent-space normal transform: drives random and directed requests,
// predicts each unit normal in fixed point and checks results in order.
// Depends on tsnt_pkg and the tangent_space_normal_transform RTL.
`timescale 1ns / 1ps

import tsnt_pkg::*;

class normal_scoreboard;
    t_out_req expected_q[$];
    int       errors;

    static function longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    static function longint signed_of(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales the magnitudes so the largest sits in [2^29, 2^30), then divides by the root.
    static function bit unit_vector(input longint v[3], output longint o[3]);
        longint unsigned u[3], m, sum, r;
        for (int i = 0; i < 3; i++) u[i] = magn(v[i]);
        m = u[0];
        if (u[1] > m) m = u[1];
        if (u[2] > m) m = u[2];
        if (m == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 0;
        end
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) u[i] = u[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) u[i] = u[i] << 1;
            m = m << 1;
        end
        sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        r = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
            o[i] = signed_of(((u[i] << FRAC_W) + r / 2) / r, v[i] < 0);
        return 1;
    endfunction

    static function longint round_frac(longint v);
        return signed_of((magn(v) + (64'd1 << (FRAC_W - 1))) >> FRAC_W, v < 0);
    endfunction

    static function longint weigh(longint a, longint b);
        return signed_of((magn(a) * magn(b)) >> SUM_SHIFT, (a < 0) != (b < 0));
    endfunction

    static function t_out_req world_normal(t_in_req q);
        longint n[3], mw[3], t[3], tn[3], b[3], s[3], o[3], hi, lo;
        longint unsigned len2;
        bit ok;
        t_out_req r;
        n[0] = q.surf_x; n[1] = q.surf_y; n[2] = q.surf_z;
        mw[0] = q.map_x; mw[1] = q.map_y; mw[2] = q.map_z;
        len2 = magn(n[0]) * magn(n[0]) + magn(n[1]) * magn(n[1]);
        if (len2 < SHORT_THRESH) begin
            t[0] = -n[2]; t[1] = 0; t[2] = n[0];
        end else begin
            t[0] = n[1]; t[1] = -n[0]; t[2] = 0;
        end
        void'(unit_vector(t, tn));
        b[0] = round_frac(n[1] * tn[2] - n[2] * tn[1]);
        b[1] = round_frac(n[2] * tn[0] - n[0] * tn[2]);
        b[2] = round_frac(n[0] * tn[1] - n[1] * tn[0]);
        for (int i = 0; i < 3; i++)
            s[i] = weigh(tn[i], mw[0]) + weigh(b[i], mw[1]) + weigh(n[i], mw[2]);
        ok = unit_vector(s, o);
        hi = (64'sd1 <<< (COMP_W - 1)) - 1;
        lo = -(64'sd1 <<< (COMP_W - 1));
        for (int i = 0; i < 3; i++) begin
            if (o[i] > hi) o[i] = hi;
            if (o[i] < lo) o[i] = lo;
        end
        r.out_x = o[0][COMP_W-1:0];
        r.out_y = o[1][COMP_W-1:0];
        r.out_z = o[2][COMP_W-1:0];
        r.degenerate = !ok;
        return r;
    endfunction

    function void note_request(t_in_req q);
        expected_q.push_back(world_normal(q));
    endfunction

    function void check_result(t_out_req a);
        t_out_req e;
        if (expected_q.size() == 0) begin
            $error("unexpected result %h", a);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (a.out_x !== e.out_x) begin
            $error("out_x expected %0d got %0d", e.out_x, a.out_x); errors++;
        end
        if (a.out_y !== e.out_y) begin
            $error("out_y expected %0d got %0d", e.out_y, a.out_y); errors++;
        end
        if (a.out_z !== e.out_z) begin
            $error("out_z expected %0d got %0d", e.out_z, a.out_z); errors++;
        end
        if (a.degenerate !== e.degenerate) begin
            $error("degenerate expected %0b got %0b", e.degenerate, a.degenerate); errors++;
        end
    endfunction
endclass

module tangent_space_normal_transform_test;
    localparam int LATENCY = 114;

    logic     i_clk = 0;
    logic     i_rst_n = 0;
    logic     i_in_valid = 0;
    t_in_req  i_in_req = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;
    logic     i_out_stall = 1;

    normal_scoreboard board = new();
    int  send_idle_pct = 20;
    int  recv_idle_pct = 51;
    bit  hold_off = 0;
    bit  stim_done = 0;

    tangent_space_normal_transform uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_request(i_in_req);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_req);
    end

    // Receiver stall; a long hold-off fills the pipe and forces an input stall.
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1;
        else i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(7))
            0: return 16'sh4000;
            1: return 16'shC000;
            2: return 16'sh7FFF;
            3: return 16'sh8000;
            4: return $urandom_range(3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(t_in_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_req <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        t_in_req q;
        repeat (count) begin
            q.surf_x = rand_comp(); q.surf_y = rand_comp(); q.surf_z = rand_comp();
            q.map_x = rand_comp(); q.map_y = rand_comp(); q.map_z = rand_comp();
            // About one request in four gets a small xy, to reach the fallback tangent.
            if ($urandom_range(3) == 0) begin
                q.surf_x = $urandom_range(2) - 1;
                q.surf_y = $urandom_range(2) - 1;
            end
            send_request(q);
        end
        i_in_valid <= 0;
    endtask

    // Waits on the clock first, so the last accepted request is already in the queue.
    task automatic drain();
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_req q;
        logic [15:0] edge_vals[6];
        edge_vals = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh8000, 16'sh0001};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: axis normals (fallback tangent), zero normal, zero map, extremes.
        for (int k = 0; k < 6; k++) begin
            q = '{edge_vals[k], edge_vals[(k+1)%6], edge_vals[(k+2)%6],
                  edge_vals[(k+3)%6], edge_vals[(k+4)%6], edge_vals[(k+5)%6]};
            send_request(q);
        end
        send_request('{16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh4000});
        send_request('{16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh4000, 16'sh4000});
        send_request('{16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
        send_request('{16'sh0, 16'sh0, 16'shC000, 16'sh4000, 16'sh0, 16'sh0});
        send_request('{16'sh0, 16'sh1, 16'sh0, 16'sh0, 16'sh4000, 16'sh0});
        send_request('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_request('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_request('{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF});
        send_request('{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
        i_in_valid <= 0;
        drain();
        send_random(250);
        // Long receiver hold-off while requests keep coming.
        hold_off = 1;
        fork
            begin
                int n;
                n = 0;
                while (n < 400) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_off = 0;
            end
            send_random(150);
        join
        drain();
        send_idle_pct = 51; recv_idle_pct = 20;
        send_random(200);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(200);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("[tangent_space_normal_transform] OK");
        else
            $display("[tangent_space_normal_transform] ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("[tangent_space_normal_transform] ERROR");
        $finish;
    end
endmodule

// File: files.f
rtl/core/tsnt_pkg.sv
rtl/core/tsnt_basis.sv
rtl/core/tsnt_norm.sv
rtl/core/tsnt_combine.sv
rtl/core/tangent_space_normal_transform.sv
tb/tangent_space_normal_transform_test.sv
